### rtl/core/sibmt_pkg.sv
// Shared types, constants and helper functions of the sparse image block map translator.
package sibmt_pkg;

	// Fixed geometry
	localparam int SECTOR_BYTES = 512;
	localparam int SECTOR_LOG2  = $clog2(SECTOR_BYTES);
	localparam int MAX_RUN      = 64;
	localparam int BSL_MIN      = 15;
	localparam int BSL_MAX      = 24;

	localparam logic [15:0] EMPTY_ENTRY = 16'hFFFF;

	// Configuration register indexes
	localparam logic [1:0] CFG_BLOCK_SIZE_LOG2 = 2'd0;
	localparam logic [1:0] CFG_DATA_START_LBA  = 2'd1;

	localparam logic [4:0]  BSL_RESET        = 5'd15;
	localparam logic [31:0] DATA_START_RESET = 32'd64;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_RANGE     = 3'd2,
		ST_BAD_ENTRY = 3'd3,
		ST_UNUSABLE  = 3'd4
	} status_t;

	// Live configuration seen by front and back
	typedef struct packed {
		logic [3:0]  shift;
		logic [31:0] data_start;
	} cfg_t;

	// Command handed from front to back
	typedef struct packed {
		logic        single;
		status_t     status;
		logic [15:0] phys;
		logic [29:0] first;
		logic [6:0]  count;
		logic [30:0] img_len;
		logic [15:0] used;
		logic [15:0] fill;
	} cmd_t;

	// Clamp block size into range and convert to an LBA shift
	function automatic logic [3:0] block_shift(input logic [4:0] bsl);
		logic [4:0] b;
		b = bsl;
		if (b < 5'(BSL_MIN)) b = 5'(BSL_MIN);
		if (b > 5'(BSL_MAX)) b = 5'(BSL_MAX);
		return 4'(b - 5'(SECTOR_LOG2));
	endfunction

	// Image length in LBAs for a given highest used block
	function automatic logic [30:0] image_len(input logic [14:0] hu, input logic [3:0] sh);
		logic [30:0] base;
		base = 31'(hu) + 31'd1;
		return base << sh;
	endfunction

endpackage

### rtl/core/sibmt_ram.sv
// Generic single write, single read RAM with registered read data.
module sibmt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32768
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/sibmt_front.sv
// Front end: accepts items, runs map loads, classifies translate requests.
module sibmt_front #(
	parameter int MAP_ENTRIES = 32768
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sibmt_pkg::cfg_t       cfg,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  op,
	input  logic [7:0]            map_byte,
	input  logic [29:0]           first_lba,
	input  logic [6:0]            lba_count,
	input  logic                  q_full,
	output logic                  q_push,
	output sibmt_pkg::cmd_t       q_cmd,
	output logic                  ram_we,
	output logic [((MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1)-1:0] ram_waddr,
	output logic [15:0]           ram_wdata
);
	import sibmt_pkg::*;

	localparam int AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

	logic [15:0] load_pos_q, load_pos_n;
	logic [15:0] next_phys_q, next_phys_n;
	logic [14:0] high_used_q, high_used_n;
	logic        failed_q, failed_n;

	logic        acc;
	logic        pos_ok;
	logic [30:0] len_cur;
	logic [6:0]  cnt_sat;
	logic [30:0] run_end;
	logic        push_n;
	logic        we_n;

	assign in_stall = q_full;
	assign acc      = in_valid && !in_stall;
	assign pos_ok   = load_pos_q < 16'(MAP_ENTRIES);
	assign len_cur  = image_len(high_used_q, cfg.shift);
	assign cnt_sat  = (lba_count > 7'(MAX_RUN)) ? 7'(MAX_RUN) : lba_count;
	assign run_end  = 31'(first_lba) + 31'(cnt_sat);

	// Classify the item and work out the next map state
	always_comb begin
		load_pos_n    = load_pos_q;
		next_phys_n   = next_phys_q;
		high_used_n   = high_used_q;
		failed_n      = failed_q;
		push_n        = 1'b1;
		we_n          = 1'b0;
		ram_wdata     = EMPTY_ENTRY;
		q_cmd         = '0;
		q_cmd.single  = 1'b1;
		q_cmd.status  = ST_OK;
		q_cmd.first   = first_lba;
		q_cmd.count   = cnt_sat;
		q_cmd.fill    = load_pos_q;
		if (op == 1'b0) begin
			if (failed_q) begin
				q_cmd.status = ST_BAD_ENTRY;
			end else if (!pos_ok) begin
				q_cmd.status = ST_RANGE;
			end else if (map_byte == 8'd0) begin
				we_n       = 1'b1;
				load_pos_n = load_pos_q + 16'd1;
			end else if (map_byte == 8'd1) begin
				we_n        = 1'b1;
				ram_wdata   = next_phys_q;
				q_cmd.phys  = next_phys_q;
				next_phys_n = next_phys_q + 16'd1;
				high_used_n = load_pos_q[14:0];
				load_pos_n  = load_pos_q + 16'd1;
			end else begin
				failed_n     = 1'b1;
				q_cmd.status = ST_BAD_ENTRY;
			end
		end else begin
			if (failed_q) begin
				q_cmd.status = ST_UNUSABLE;
			end else if (run_end > len_cur) begin
				q_cmd.status = ST_RANGE;
			end else if (cnt_sat == 7'd0) begin
				push_n = 1'b0;
			end else begin
				q_cmd.single = 1'b0;
			end
		end
		q_cmd.img_len = image_len(high_used_n, cfg.shift);
		q_cmd.used    = next_phys_n;
	end

	assign q_push    = acc && push_n;
	assign ram_we    = acc && we_n;
	assign ram_waddr = load_pos_q[AW-1:0];

	// Update map state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q  <= '0;
			next_phys_q <= '0;
			high_used_q <= '0;
			failed_q    <= 1'b0;
		end else if (acc) begin
			load_pos_q  <= load_pos_n;
			next_phys_q <= next_phys_n;
			high_used_q <= high_used_n;
			failed_q    <= failed_n;
		end
	end

endmodule

### rtl/core/sibmt_cmdq.sv
// Short command queue between front and back.
module sibmt_cmdq #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sibmt_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output sibmt_pkg::cmd_t head
);
	import sibmt_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cmd_t         slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   cnt_q;

	assign full  = cnt_q == (PW+1)'(DEPTH);
	assign valid = cnt_q != '0;
	assign head  = slot_q[rd_ptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/sibmt_back.sv
// Back end: walks translate runs through the block table and drives results.
module sibmt_back #(
	parameter int MAP_ENTRIES = 32768
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sibmt_pkg::cfg_t       cfg,
	input  logic                  q_valid,
	input  sibmt_pkg::cmd_t       q_head,
	output logic                  q_pop,
	output logic                  ram_re,
	output logic [((MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1)-1:0] ram_raddr,
	input  logic [15:0]           ram_rdata,
	output logic                  out_valid,
	input  logic                  out_stall,
	output sibmt_pkg::status_t    out_status,
	output logic [32:0]           out_phys,
	output logic [5:0]            out_offset,
	output logic                  out_last,
	output logic [30:0]           out_len,
	output logic [15:0]           out_used
);
	import sibmt_pkg::*;

	localparam int AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

	// Run sequencer
	logic        busy_q;
	cmd_t        cur_q;
	logic [6:0]  k_q;

	// Read stage
	logic        vld_s1;
	logic        single_s1;
	status_t     status_s1;
	logic [15:0] phys_s1;
	logic [5:0]  off_s1;
	logic        last_s1;
	logic [30:0] len_s1;
	logic [15:0] used_s1;
	logic [29:0] lba_s1;
	logic        hit_s1;

	// Output register
	logic        out_valid_q;

	logic        adv;
	logic        issue;
	cmd_t        src;
	logic [6:0]  k_src;
	logic [30:0] lba;
	logic [30:0] idx;
	logic        src_last;
	logic        hit;
	logic [29:0] off_mask;
	status_t     res_status;
	logic [32:0] res_phys;

	assign adv      = !out_valid_q || !out_stall;
	assign src      = busy_q ? cur_q : q_head;
	assign k_src    = busy_q ? k_q : 7'd0;
	assign issue    = adv && (busy_q || q_valid);
	assign q_pop    = adv && !busy_q && q_valid;
	assign lba      = 31'(src.first) + 31'(k_src);
	assign idx      = lba >> cfg.shift;
	assign hit      = idx < 31'(src.fill);
	assign src_last = src.single || ((k_src + 7'd1) == src.count);
	assign ram_re   = issue && !src.single;
	assign ram_raddr = idx[AW-1:0];
	assign off_mask = (30'd1 << cfg.shift) - 30'd1;

	// Step through the run, one LBA per cycle while the output is not stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (issue) begin
			if (busy_q) begin
				if (src_last) begin
					busy_q <= 1'b0;
				end else begin
					k_q <= k_q + 7'd1;
				end
			end else if (!src_last) begin
				busy_q <= 1'b1;
				k_q    <= 7'd1;
			end
		end
	end

	// Latch the popped run command
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
	end

	// Read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= issue;
		end
	end

	// Read stage payload
	always_ff @(posedge clk) begin
		if (adv && issue) begin
			single_s1 <= src.single;
			status_s1 <= src.status;
			phys_s1   <= src.phys;
			off_s1    <= src.single ? 6'd0 : k_src[5:0];
			last_s1   <= src_last;
			len_s1    <= src.img_len;
			used_s1   <= src.used;
			lba_s1    <= lba[29:0];
			hit_s1    <= hit;
		end
	end

	// Form the result from the table entry, or from the command for a single result
	always_comb begin
		if (single_s1) begin
			res_status = status_s1;
			res_phys   = 33'(phys_s1);
		end else if (!hit_s1 || ram_rdata == EMPTY_ENTRY) begin
			res_status = ST_EMPTY;
			res_phys   = '0;
		end else begin
			res_status = ST_OK;
			res_phys   = (33'(ram_rdata) << cfg.shift) + 33'(lba_s1 & off_mask)
			           + 33'(cfg.data_start);
		end
	end

	// Output register, advances when empty or taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			out_status <= res_status;
			out_phys   <= res_phys;
			out_offset <= off_s1;
			out_last   <= last_s1;
			out_len    <= len_s1;
			out_used   <= used_s1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/core/sparse_image_block_map_translator_top.sv
// Top level of the sparse image block map translator.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  cfg     | in        | cfg_we               | cfg_idx, cfg_wdata
//  in      | in        | in_valid / in_stall  | op, map_byte, first_lba, lba_count
//  out     | out       | out_valid / out_stall| status, phys_lba, run_offset, last,
//          |           |                      | image_lba_len, blocks_used
//
// A load or a single status result gives one result; a translate run of n LBAs makes
// one block table read per cycle on the RAM read port while out_stall does not hold the
// back, and each result passes through the read stage and the output register.
// Reset needs no table clearing pass: entries at or beyond the load position read as empty.
// The front stalls input only when the command queue is full; out_stall holds the back.
module sparse_image_block_map_translator_top #(
	parameter int MAP_ENTRIES = 32768,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  map_byte,
	input  logic [29:0] first_lba,
	input  logic [6:0]  lba_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [32:0] phys_lba,
	output logic [5:0]  run_offset,
	output logic        last,
	output logic [30:0] image_lba_len,
	output logic [15:0] blocks_used
);
	import sibmt_pkg::*;

	localparam int AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

	logic [4:0]  bsl_q;
	logic [31:0] data_start_q;
	cfg_t        cfg;

	logic        q_full;
	logic        q_push;
	cmd_t        q_cmd;
	logic        q_pop;
	logic        q_valid;
	cmd_t        q_head;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;

	status_t     out_status;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsl_q        <= BSL_RESET;
			data_start_q <= DATA_START_RESET;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_BLOCK_SIZE_LOG2) begin
				bsl_q <= cfg_wdata[4:0];
			end else if (cfg_idx == CFG_DATA_START_LBA) begin
				data_start_q <= cfg_wdata;
			end
		end
	end

	assign cfg.shift      = block_shift(bsl_q);
	assign cfg.data_start = data_start_q;

	sibmt_front #(
		.MAP_ENTRIES(MAP_ENTRIES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.map_byte  (map_byte),
		.first_lba (first_lba),
		.lba_count (lba_count),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_cmd),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	sibmt_cmdq #(
		.DEPTH(QUEUE_DEPTH)
	) u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	sibmt_ram #(
		.WIDTH(16),
		.DEPTH(MAP_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sibmt_back #(
		.MAP_ENTRIES(MAP_ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_status (out_status),
		.out_phys   (phys_lba),
		.out_offset (run_offset),
		.out_last   (last),
		.out_len    (image_lba_len),
		.out_used   (blocks_used)
	);

	assign status = out_status;

endmodule

### dv/sibmt_checker.sv
// Checker for the block map translator: predicts every result from the input and config ports.
`timescale 1ns / 1ps

module sibmt_checker #(
	parameter int MAP_ENTRIES = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        op,
	input  logic [7:0]  map_byte,
	input  logic [29:0] first_lba,
	input  logic [6:0]  lba_count,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [32:0] phys_lba,
	input  logic [5:0]  run_offset,
	input  logic        last,
	input  logic [30:0] image_lba_len,
	input  logic [15:0] blocks_used,
	output int          errors,
	output int          pending
);
	import sibmt_pkg::*;

	typedef struct packed {
		status_t     status;
		logic [32:0] phys;
		logic [5:0]  offset;
		logic        last;
		logic [30:0] img_len;
		logic [15:0] used;
	} lba_result_t;

	lba_result_t expected_q[$];

	// Mirror of the block map and load state
	logic [15:0] map_tbl [MAP_ENTRIES];
	logic [16:0] load_pos;
	logic [15:0] next_blk;
	logic [14:0] top_used;
	logic        map_bad;
	logic [4:0]  bsl;
	logic [31:0] data_start;

	// Clamp the block size and convert it to an LBA shift
	function automatic int unsigned lba_shift();
		int unsigned b;
		b = bsl;
		if (b < BSL_MIN) b = BSL_MIN;
		if (b > BSL_MAX) b = BSL_MAX;
		return b - SECTOR_LOG2;
	endfunction

	function automatic logic [63:0] image_span();
		return (64'(top_used) + 64'd1) << lba_shift();
	endfunction

	task automatic add_result(input status_t st, input logic [32:0] ph, input logic [5:0] off,
			input logic lst);
		lba_result_t r;
		r.status  = st;
		r.phys    = ph;
		r.offset  = off;
		r.last    = lst;
		r.img_len = 31'(image_span());
		r.used    = next_blk;
		expected_q.push_back(r);
	endtask

	// Work out the results of one accepted input transaction
	task automatic predict_item();
		logic [63:0] n, lba, idx, mask, ph;
		logic [15:0] ent;
		int unsigned sh;
		if (op == 1'b0) begin
			if (map_bad) begin
				add_result(ST_BAD_ENTRY, '0, '0, 1'b1);
			end else if (load_pos >= 17'(MAP_ENTRIES)) begin
				add_result(ST_RANGE, '0, '0, 1'b1);
			end else if (map_byte == 8'd0) begin
				load_pos = load_pos + 17'd1;
				add_result(ST_OK, '0, '0, 1'b1);
			end else if (map_byte == 8'd1) begin
				ph = 64'(next_blk);
				map_tbl[load_pos[14:0]] = next_blk;
				next_blk = next_blk + 16'd1;
				top_used = load_pos[14:0];
				load_pos = load_pos + 17'd1;
				add_result(ST_OK, 33'(ph), '0, 1'b1);
			end else begin
				map_bad = 1'b1;
				add_result(ST_BAD_ENTRY, '0, '0, 1'b1);
			end
		end else if (map_bad) begin
			add_result(ST_UNUSABLE, '0, '0, 1'b1);
		end else begin
			n = 64'(lba_count);
			if (n > 64'(MAX_RUN)) n = 64'(MAX_RUN);
			if (64'(first_lba) + n > image_span()) begin
				add_result(ST_RANGE, '0, '0, 1'b1);
			end else begin
				sh = lba_shift();
				mask = (64'd1 << sh) - 64'd1;
				for (int k = 0; k < int'(n); k++) begin
					lba = 64'(first_lba) + 64'(k);
					idx = lba >> sh;
					ent = (idx < 64'(MAP_ENTRIES)) ? map_tbl[idx[14:0]] : EMPTY_ENTRY;
					if (ent == EMPTY_ENTRY) begin
						add_result(ST_EMPTY, '0, 6'(k), 64'(k + 1) == n);
					end else begin
						ph = (64'(ent) << sh) + (lba & mask) + 64'(data_start);
						add_result(ST_OK, 33'(ph), 6'(k), 64'(k + 1) == n);
					end
				end
			end
		end
	endtask

	// Compare one accepted result with the oldest expectation
	task automatic check_result();
		lba_result_t e;
		if (expected_q.size() == 0) begin
			$error("result with nothing expected: status %0d phys_lba %0d", status, phys_lba);
			errors++;
		end else begin
			e = expected_q.pop_front();
			if (status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, status);
				errors++;
			end
			if (phys_lba !== e.phys) begin
				$error("phys_lba: expected %0d, actual %0d", e.phys, phys_lba);
				errors++;
			end
			if (run_offset !== e.offset) begin
				$error("run_offset: expected %0d, actual %0d", e.offset, run_offset);
				errors++;
			end
			if (last !== e.last) begin
				$error("last: expected %0d, actual %0d", e.last, last);
				errors++;
			end
			if (image_lba_len !== e.img_len) begin
				$error("image_lba_len: expected %0d, actual %0d", e.img_len, image_lba_len);
				errors++;
			end
			if (blocks_used !== e.used) begin
				$error("blocks_used: expected %0d, actual %0d", e.used, blocks_used);
				errors++;
			end
		end
	endtask

	// Retire results first: a result can never belong to an item accepted at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_ENTRIES; i++) map_tbl[i] = EMPTY_ENTRY;
			load_pos   = '0;
			next_blk   = '0;
			top_used   = '0;
			map_bad    = 1'b0;
			bsl        = BSL_RESET;
			data_start = DATA_START_RESET;
			errors     = 0;
			pending    = 0;
			expected_q.delete();
		end else begin
			if (out_valid && !out_stall) check_result();
			if (cfg_we) begin
				if (cfg_idx == CFG_BLOCK_SIZE_LOG2) bsl = cfg_wdata[4:0];
				else if (cfg_idx == CFG_DATA_START_LBA) data_start = cfg_wdata;
			end
			if (in_valid && !in_stall) predict_item();
			pending = expected_q.size();
		end
	end

endmodule

### dv/testbench.sv
// Testbench top: drives map loads, translate runs and config writes, and reports the verdict.
`timescale 1ns / 1ps

module testbench;
	import sibmt_pkg::*;

	localparam int MAP_ENTRIES = 32768;
	localparam int CYCLE_LIMIT = 2_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = '0;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = 1'b0;
	logic [7:0]  map_byte = '0;
	logic [29:0] first_lba = '0;
	logic [6:0]  lba_count = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [32:0] phys_lba;
	logic [5:0]  run_offset;
	logic        last;
	logic [30:0] image_lba_len;
	logic [15:0] blocks_used;
	int          errors;
	int          pending;

	// Idle rates in percent and the stimulus view of the map
	int          snd_idle = 31;
	int          rcv_idle = 52;
	int          cycles = 0;
	int unsigned loaded = 0;
	int unsigned top_hu = 0;
	logic [4:0]  cur_bsl = BSL_RESET;

	sparse_image_block_map_translator_top i_dut (.*);

	sibmt_checker #(.MAP_ENTRIES(MAP_ENTRIES)) i_checker (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the result channel at random
	always @(posedge clk) begin
		out_stall <= (rcv_idle > 0) && ($urandom_range(99) < rcv_idle);
	end

	// Abort a hung run
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("sparse_image_block_map_translator_top test failed");
		$finish;
	end

	// Present one input transaction and hold it until accepted
	task automatic send_item(input logic o, input logic [7:0] b, input logic [29:0] f,
			input logic [6:0] c);
		logic stalled;
		if (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle);
		end
		in_valid  <= 1'b1;
		op        <= o;
		map_byte  <= b;
		first_lba <= f;
		lba_count <= c;
		forever begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
			if (!stalled) break;
		end
	endtask

	// Load a well-formed map byte and track the image length
	task automatic load_byte(input logic used);
		send_item(1'b0, {7'd0, used}, 30'($urandom()), 7'($urandom()));
		if (used) top_hu = loaded;
		loaded++;
	endtask

	task automatic translate(input logic [29:0] f, input logic [6:0] c);
		send_item(1'b1, 8'($urandom()), f, c);
	endtask

	function automatic logic [63:0] image_span();
		int unsigned b;
		b = cur_bsl;
		if (b < BSL_MIN) b = BSL_MIN;
		if (b > BSL_MAX) b = BSL_MAX;
		return (64'(top_hu) + 64'd1) << (b - SECTOR_LOG2);
	endfunction

	// Mostly in-range runs, plus zero counts, oversized counts and far-off LBAs
	task automatic random_translate();
		logic [63:0] span;
		logic [29:0] f;
		logic [6:0]  c;
		int unsigned pick;
		span = image_span();
		pick = $urandom_range(99);
		if (pick < 8) c = 7'd0;
		else if (pick < 16) c = 7'($urandom_range(127, 65));
		else if (pick < 60) c = 7'($urandom_range(8, 1));
		else c = 7'($urandom_range(64, 9));
		pick = $urandom_range(99);
		if (pick < 12) f = 30'($urandom());
		else if (pick < 22) f = 30'(span - 64'($urandom_range(64, 1)));
		else f = 30'($urandom_range(32'(span - 64'd1)));
		translate(f, c);
	endtask

	// Hold input until every expected result has come
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// Drain, then wait before a register write
	task automatic settle();
		drain();
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_idx   <= idx;
		cfg_wdata <= val;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_BLOCK_SIZE_LOG2) cur_bsl = val[4:0];
	endtask

	task automatic random_round(input int n);
		for (int i = 0; i < n; i++) begin
			if (i == n / 2) drain();
			if ($urandom_range(99) < 35) load_byte($urandom_range(99) < 55);
			else random_translate();
		end
	endtask

	initial begin
		logic [4:0] bsl_set [6];
		logic [63:0] span;
		bsl_set = '{5'd0, 5'd24, 5'd31, 5'd20, 5'd14, 5'd17};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty map: the image is still one block long
		translate(30'd0, 7'd1);
		translate(30'd63, 7'd1);
		translate(30'd63, 7'd2);
		translate(30'd0, 7'd0);
		translate(30'h3FFFFFFF, 7'd127);
		// Partial map with a hole in the middle
		load_byte(1'b1);
		load_byte(1'b0);
		load_byte(1'b0);
		load_byte(1'b1);
		translate(30'd0, 7'd64);
		translate(30'd60, 7'd127);
		translate(30'd192, 7'd64);
		translate(30'd193, 7'd64);
		translate(30'd255, 7'd1);
		translate(30'd100, 7'd0);
		load_byte(1'b1);

		// Block size below and above range saturates
		settle();
		write_reg(CFG_BLOCK_SIZE_LOG2, 32'd0);
		write_reg(CFG_DATA_START_LBA, 32'hFFFFFFFF);
		translate(30'd0, 7'd64);
		settle();
		write_reg(CFG_BLOCK_SIZE_LOG2, 32'd31);
		span = image_span();
		translate(30'd0, 7'd64);
		translate(30'(span - 64'd64), 7'd64);
		translate(30'(span - 64'd63), 7'd64);

		// Random rounds over the idle schedule
		for (int r = 0; r < 6; r++) begin
			if (r == 2) begin
				snd_idle = 52;
				rcv_idle = 31;
			end else if (r == 4) begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			settle();
			write_reg(CFG_BLOCK_SIZE_LOG2, 32'(bsl_set[r]));
			case (r % 3)
				0: write_reg(CFG_DATA_START_LBA, 32'd0);
				1: write_reg(CFG_DATA_START_LBA, 32'hFFFFFFFF);
				default: write_reg(CFG_DATA_START_LBA, $urandom());
			endcase
			random_round(48);
		end

		// Largest block size with a random data start; translate at the top of the image
		settle();
		write_reg(CFG_BLOCK_SIZE_LOG2, 32'd24);
		write_reg(CFG_DATA_START_LBA, $urandom());
		load_byte(1'b1);
		span = image_span();
		translate(30'(span - 64'd1), 7'd1);
		translate(30'(span - 64'd64), 7'd64);
		translate(30'(span), 7'd1);
		translate(30'h3FFFFFFF, 7'd1);
		repeat (16) random_translate();

		// Invalid map byte, then loads and translates on an unusable map
		send_item(1'b0, 8'h02, 30'd0, 7'd0);
		send_item(1'b0, 8'hFF, 30'd0, 7'd0);
		send_item(1'b0, 8'h00, 30'd0, 7'd0);
		send_item(1'b0, 8'h01, 30'd0, 7'd0);
		repeat (4) send_item(1'b0, 8'($urandom()), 30'($urandom()), 7'($urandom()));
		translate(30'd0, 7'd1);
		repeat (3) translate(30'($urandom()), 7'($urandom()));

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("sparse_image_block_map_translator_top test passed");
		end else begin
			$display("sparse_image_block_map_translator_top test failed");
		end
		$finish;
	end

endmodule

### sparse_image_block_map_translator_top.f
rtl/core/sibmt_pkg.sv
rtl/core/sibmt_ram.sv
rtl/core/sibmt_front.sv
rtl/core/sibmt_cmdq.sv
rtl/core/sibmt_back.sv
rtl/core/sparse_image_block_map_translator_top.sv
dv/sibmt_checker.sv
dv/testbench.sv
